// ===== rtl/tcrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS control record classifier package
// Shared types and constants for the record walker and the top level.
// ----------------------------------------------------------------------------
package tcrc_pkg;

   // Field widths.
   localparam int unsigned TypeWidth   = 8;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned LengthWidth = 24;

   // TLS content types.
   localparam logic [TypeWidth-1:0] TYPE_CCS       = 8'd20;
   localparam logic [TypeWidth-1:0] TYPE_ALERT     = 8'd21;
   localparam logic [TypeWidth-1:0] TYPE_HANDSHAKE = 8'd22;

   // Handshake message type that is allowed, and the close notify alert code.
   localparam logic [ByteWidth-1:0] HS_TICKET          = 8'd4;
   localparam logic [ByteWidth-1:0] ALERT_CLOSE_NOTIFY = 8'd0;

   // Verdict codes.
   typedef enum logic [1:0] {
      ACT_RETRY = 2'd0,
      ACT_EOF   = 2'd1,
      ACT_CLOSE = 2'd2
   } action_type;

   // One input item as held in the input register.
   typedef struct packed {
      logic [TypeWidth-1:0] content_type;
      logic [ByteWidth-1:0] data_byte;
      logic                 has_byte;
      logic                 last;
   } item_type;

endpackage

// ===== rtl/tcrc_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS control record walker
// Holds the per-record parse state, advances it by one item per step and
// gives the verdict for the record on its last item.
// ----------------------------------------------------------------------------
module tcrc_walker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  tcrc_pkg::item_type   item,
   output tcrc_pkg::action_type action
);

   // Parse state registers.
   logic [1:0]                          hdr_ff, hdr_in;
   logic [tcrc_pkg::LengthWidth-1:0]    rem_ff, rem_in;
   logic [tcrc_pkg::LengthWidth-1:0]    acc_ff, acc_in;
   logic                                close_ff, close_in;
   logic [1:0]                          pos_ff, pos_in;
   logic                                zero_ff, zero_in;

   // State after the item's byte is taken, before the end-of-record clear.
   logic [1:0]                          hdr_take;
   logic [tcrc_pkg::LengthWidth-1:0]    rem_take;
   logic [tcrc_pkg::LengthWidth-1:0]    acc_take;
   logic                                close_take;
   logic [1:0]                          pos_take;
   logic                                zero_take;

   // Take one byte: track the alert code and walk the message headers.
   always_comb begin
      hdr_take   = hdr_ff;
      rem_take   = rem_ff;
      acc_take   = acc_ff;
      close_take = close_ff;
      pos_take   = pos_ff;
      zero_take  = zero_ff;
      if (item.has_byte) begin
         if (pos_ff == 2'd1) begin
            zero_take = (item.data_byte == tcrc_pkg::ALERT_CLOSE_NOTIFY);
         end
         if (pos_ff < 2'd2) begin
            pos_take = pos_ff + 2'd1;
         end
         if (hdr_ff == 2'd0) begin
            if (rem_ff != '0) begin
               rem_take = rem_ff - {{(tcrc_pkg::LengthWidth-1){1'b0}}, 1'b1};
            end else begin
               if (item.data_byte != tcrc_pkg::HS_TICKET) begin
                  close_take = 1'b1;
               end
               acc_take = '0;
               hdr_take = 2'd1;
            end
         end else begin
            acc_take = {acc_ff[tcrc_pkg::LengthWidth-tcrc_pkg::ByteWidth-1:0],
                        item.data_byte};
            if (hdr_ff == 2'd3) begin
               rem_take = acc_take;
               hdr_take = 2'd0;
            end else begin
               hdr_take = hdr_ff + 2'd1;
            end
         end
      end
   end

   // Verdict from the state after this item's byte.
   always_comb begin
      if (item.content_type == tcrc_pkg::TYPE_CCS) begin
         action = tcrc_pkg::ACT_RETRY;
      end else if (item.content_type == tcrc_pkg::TYPE_ALERT) begin
         action = (pos_take == 2'd2 && zero_take) ? tcrc_pkg::ACT_EOF
                                                  : tcrc_pkg::ACT_CLOSE;
      end else if (item.content_type == tcrc_pkg::TYPE_HANDSHAKE) begin
         action = (close_take || hdr_take != 2'd0 || rem_take != '0)
                  ? tcrc_pkg::ACT_CLOSE : tcrc_pkg::ACT_RETRY;
      end else begin
         action = tcrc_pkg::ACT_CLOSE;
      end
   end

   // Next state: the last item of a record clears everything.
   always_comb begin
      hdr_in   = hdr_ff;
      rem_in   = rem_ff;
      acc_in   = acc_ff;
      close_in = close_ff;
      pos_in   = pos_ff;
      zero_in  = zero_ff;
      if (step) begin
         if (item.last) begin
            hdr_in   = 2'd0;
            rem_in   = '0;
            acc_in   = '0;
            close_in = 1'b0;
            pos_in   = 2'd0;
            zero_in  = 1'b0;
         end else begin
            hdr_in   = hdr_take;
            rem_in   = rem_take;
            acc_in   = acc_take;
            close_in = close_take;
            pos_in   = pos_take;
            zero_in  = zero_take;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff   <= 2'd0;
         rem_ff   <= '0;
         acc_ff   <= '0;
         close_ff <= 1'b0;
         pos_ff   <= 2'd0;
         zero_ff  <= 1'b0;
      end else begin
         hdr_ff   <= hdr_in;
         rem_ff   <= rem_in;
         acc_ff   <= acc_in;
         close_ff <= close_in;
         pos_ff   <= pos_in;
         zero_ff  <= zero_in;
      end
   end

`ifndef SYNTHESIS
   // While length bytes are collected, no message body is owed.
   a_hdr_no_body: assert property (@(posedge clock) disable iff (reset)
      hdr_ff != 2'd0 |-> rem_ff == '0)
      else $error("body count nonzero inside a message header");

   // The byte position saturates at two.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff != 2'd3)
      else $error("byte position past saturation");

   // The last item of a record leaves a clean state behind.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      step && item.last |=> hdr_ff == 2'd0 && rem_ff == '0 && !close_ff
                            && pos_ff == 2'd0)
      else $error("state not cleared after the last item");
`endif

endmodule

// ===== rtl/tls_control_record_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS control record classifier
// Walks the body of a non-data TLS record one byte per item and gives one
// verdict (retry, end of stream or close) on the record's last item.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel takes one item per cycle: the record's content type, one
//   body byte with its has_byte flag, and last on the record's final item.
//   An item with has_byte low and last low changes nothing.
//   The rsp_ channel carries one rsp_action for each item with last set,
//   in record order; other items give no result.
//   Results are registered: an accepted last item waits in the input
//   register, and its verdict is loaded into the result register when the
//   item leaves it, which a held result can delay.
//   Throughput: one item per clock while req_stall is low. Each item takes
//   one pass through the walker's next-state logic between the input and
//   result registers, so a new item can follow in the next cycle.
//   When rsp_stall is high, the result register holds its item; items with
//   no result keep flowing, and req_stall rises only when a last item waits
//   behind a stalled result.
//   Reset (synchronous, active high) empties both registers and clears the
//   walk state, so the next item starts a new record.
// ----------------------------------------------------------------------------
module tls_control_record_classifier (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tcrc_pkg::TypeWidth-1:0] req_content_type,
   input  logic [tcrc_pkg::ByteWidth-1:0] req_data_byte,
   input  logic                           req_has_byte,
   input  logic                           req_last,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_action
);

   logic                 in_valid_ff, in_valid_in;
   tcrc_pkg::item_type   in_item_ff, in_item_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_action_ff, rsp_action_in;
   logic                 rsp_free;
   logic                 advance;
   logic                 load_rsp;
   logic                 req_take;
   tcrc_pkg::action_type walk_action;

   // Flow control: an item leaves the input register unless it needs the
   // result register while that one is still held.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_item_ff.last || rsp_free);
   assign load_rsp  = advance && in_item_ff.last;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in             = 1'b1;
         in_item_in.content_type = req_content_type;
         in_item_in.data_byte    = req_data_byte;
         in_item_in.has_byte     = req_has_byte;
         in_item_in.last         = req_last;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Record walker.
   tcrc_walker u_walker (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .action (walk_action)
   );

   // Result register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_action_in = rsp_action_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_action_in = walk_action;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_item_ff    <= in_item_in;
      rsp_action_ff <= rsp_action_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_action = rsp_action_ff;

`ifndef SYNTHESIS
   // Stalling the request side only happens with an item waiting inside.
   a_stall_has_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_item_ff.last && rsp_valid_ff)
      else $error("request stalled without a waiting last item");

   // A new result never overwrites one that is still held.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !load_rsp)
      else $error("result register overwritten while stalled");

   // A stalled result stays valid and keeps its verdict.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_action_ff))
      else $error("stalled result changed");
`endif

endmodule

// ===== tb/sv/tls_control_record_classifier_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS control record classifier checker
// Watches both channels of the classifier. It keeps its own copy of the
// record walk and queues one expected verdict for each accepted last item.
// Each accepted result is compared with the oldest queued verdict.
// ----------------------------------------------------------------------------
module tls_control_record_classifier_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_content_type,
   input  logic [7:0] req_data_byte,
   input  logic       req_has_byte,
   input  logic       req_last,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_action,
   output int         mismatch_count,
   output int         pending_verdicts,
   output int         verdicts_checked
);

   // Walk state of the record in progress.
   logic [2:0]  hdr_idx;
   logic [23:0] body_left;
   logic [23:0] len_acc;
   logic        bad_msg_seen;
   logic [1:0]  byte_pos;
   logic        alert_zero;

   tcrc_pkg::action_type verdict_queue[$];

   // Start a new record.
   function void clear_walk();
      hdr_idx      = 3'd0;
      body_left    = 24'd0;
      len_acc      = 24'd0;
      bad_msg_seen = 1'b0;
      byte_pos     = 2'd0;
      alert_zero   = 1'b0;
   endfunction

   // Advance the walk by one body byte: message type, three length bytes,
   // then the message body.
   function void walk_byte(input logic [7:0] value);
      if (byte_pos == 2'd1) begin
         alert_zero = (value == tcrc_pkg::ALERT_CLOSE_NOTIFY);
      end
      if (byte_pos < 2'd2) begin
         byte_pos = byte_pos + 2'd1;
      end
      if (hdr_idx == 3'd0) begin
         if (body_left != 24'd0) begin
            body_left = body_left - 24'd1;
         end else begin
            if (value != tcrc_pkg::HS_TICKET) begin
               bad_msg_seen = 1'b1;
            end
            len_acc = 24'd0;
            hdr_idx = 3'd1;
         end
      end else begin
         len_acc = {len_acc[15:0], value};
         if (hdr_idx >= 3'd3) begin
            body_left = len_acc;
            hdr_idx   = 3'd0;
         end else begin
            hdr_idx = hdr_idx + 3'd1;
         end
      end
   endfunction

   // Verdict for the record, taken from the type tag of its last item.
   function tcrc_pkg::action_type classify_record(input logic [7:0] rtype);
      if (rtype == tcrc_pkg::TYPE_CCS) begin
         return tcrc_pkg::ACT_RETRY;
      end
      if (rtype == tcrc_pkg::TYPE_ALERT) begin
         return (byte_pos >= 2'd2 && alert_zero) ? tcrc_pkg::ACT_EOF
                                                 : tcrc_pkg::ACT_CLOSE;
      end
      if (rtype == tcrc_pkg::TYPE_HANDSHAKE) begin
         if (bad_msg_seen || hdr_idx != 3'd0 || body_left != 24'd0) begin
            return tcrc_pkg::ACT_CLOSE;
         end
         return tcrc_pkg::ACT_RETRY;
      end
      return tcrc_pkg::ACT_CLOSE;
   endfunction

   // Check results first, then predict, so that an unexpected result is never
   // matched against a verdict queued at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_walk();
         verdict_queue.delete();
         mismatch_count   = 0;
         verdicts_checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_queue.size() == 0) begin
               $error("rsp_action: got %0d with no verdict expected", rsp_action);
               mismatch_count++;
            end else begin
               if (rsp_action !== verdict_queue[0]) begin
                  $error("rsp_action: expected %0d, got %0d",
                         verdict_queue[0], rsp_action);
                  mismatch_count++;
               end
               void'(verdict_queue.pop_front());
               verdicts_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            if (req_has_byte) begin
               walk_byte(req_data_byte);
            end
            if (req_last) begin
               verdict_queue.push_back(classify_record(req_content_type));
               clear_walk();
            end
         end
      end
      pending_verdicts = verdict_queue.size();
   end

endmodule

// ===== tb/sv/tls_control_record_classifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS control record classifier testbench
// Sends directed records and then random records (change cipher spec, alert,
// handshake and other types), with random idle gaps on the sender and random
// stalls on the receiver in some phases. The checker module predicts and compares verdicts.
// ----------------------------------------------------------------------------
module tls_control_record_classifier_tb;

   localparam int ClockHalf   = 6;
   localparam int CycleLimit  = 400000;
   localparam int PhaseItems  = 450;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [7:0] req_content_type = 8'd0;
   logic [7:0] req_data_byte    = 8'd0;
   logic       req_has_byte     = 1'b0;
   logic       req_last         = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [1:0] rsp_action;

   int mismatch_count;
   int pending_verdicts;
   int verdicts_checked;

   int cycle_count   = 0;
   int items_sent    = 0;
   int records_sent  = 0;
   bit send_gaps     = 1'b1;
   bit rsp_holds     = 1'b1;

   logic [7:0] record_body[$];

   always #ClockHalf clock = ~clock;

   tls_control_record_classifier dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_content_type (req_content_type),
      .req_data_byte    (req_data_byte),
      .req_has_byte     (req_has_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_action       (rsp_action)
   );

   tls_control_record_classifier_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_content_type (req_content_type),
      .req_data_byte    (req_data_byte),
      .req_has_byte     (req_has_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_action       (rsp_action),
      .mismatch_count   (mismatch_count),
      .pending_verdicts (pending_verdicts),
      .verdicts_checked (verdicts_checked)
   );

   // Run guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("[tls_control_record_classifier] ERROR");
         $finish;
      end
   end

   // Receiver: after each accepted result, stall for a random number of cycles.
   initial begin : rsp_side
      int hold;
      forever begin
         hold = rsp_holds ? $urandom_range(0, 5) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Present one item after an optional idle gap and wait until it is taken.
   task automatic push_item(input logic [7:0] rtype, input logic [7:0] value,
                            input logic has, input logic fin);
      int gap;
      gap = send_gaps ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_content_type <= rtype;
      req_data_byte    <= value;
      req_has_byte     <= has;
      req_last         <= fin;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Send record_body as one record. Items with no byte are slipped in now
   // and then, and some records end on an extra item that carries no byte.
   task automatic send_record(input logic [7:0] rtype, input bit mixed_tags);
      bit empty_end;
      logic [7:0] tag;
      empty_end = (record_body.size() == 0) || ($urandom_range(0, 3) == 0);
      foreach (record_body[i]) begin
         if ($urandom_range(0, 7) == 0) begin
            push_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      1'b0, 1'b0);
         end
         if (i == record_body.size() - 1 && !empty_end) begin
            push_item(rtype, record_body[i], 1'b1, 1'b1);
         end else begin
            tag = mixed_tags ? 8'($urandom_range(0, 255)) : rtype;
            push_item(tag, record_body[i], 1'b1, 1'b0);
         end
      end
      if (empty_end) begin
         push_item(rtype, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
      records_sent++;
   endtask

   // Append one handshake message header and some of its body bytes.
   task automatic add_message(input logic [7:0] msg_type, input logic [23:0] length,
                              input int body_bytes);
      record_body.push_back(msg_type);
      record_body.push_back(length[23:16]);
      record_body.push_back(length[15:8]);
      record_body.push_back(length[7:0]);
      repeat (body_bytes) record_body.push_back(8'($urandom_range(0, 255)));
   endtask

   // Sender: reset, directed records, then four phases of random records.
   initial begin : req_side
      int phase;
      int phase_end;
      int kind;
      int count;
      logic [23:0] length;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty records of each kind of type.
      record_body.delete();
      send_record(tcrc_pkg::TYPE_CCS, 1'b0);
      send_record(tcrc_pkg::TYPE_ALERT, 1'b0);
      send_record(tcrc_pkg::TYPE_HANDSHAKE, 1'b0);
      send_record(8'hFF, 1'b0);
      // Change cipher spec and alerts: close notify, then another code.
      record_body = '{8'hFF};
      send_record(tcrc_pkg::TYPE_CCS, 1'b0);
      record_body = '{8'd2, tcrc_pkg::ALERT_CLOSE_NOTIFY};
      send_record(tcrc_pkg::TYPE_ALERT, 1'b0);
      record_body = '{8'd2, 8'd1};
      send_record(tcrc_pkg::TYPE_ALERT, 1'b0);
      // Clean ticket with a body, bytes tagged with other types on the way.
      record_body.delete();
      add_message(tcrc_pkg::HS_TICKET, 24'd1, 1);
      record_body[4] = 8'h5A;
      send_record(tcrc_pkg::TYPE_HANDSHAKE, 1'b1);
      // Bad message type, truncated header, and a length past the record end.
      record_body = '{8'd1, 8'd0, 8'd0, 8'd0};
      send_record(tcrc_pkg::TYPE_HANDSHAKE, 1'b0);
      record_body = '{tcrc_pkg::HS_TICKET, 8'd0, 8'd0};
      send_record(tcrc_pkg::TYPE_HANDSHAKE, 1'b0);
      record_body = '{tcrc_pkg::HS_TICKET, 8'h80, 8'h00, 8'h00};
      send_record(tcrc_pkg::TYPE_HANDSHAKE, 1'b0);

      for (phase = 0; phase < 4; phase++) begin
         // Drain everything before the idling pattern changes.
         req_valid <= 1'b0;
         do @(negedge clock); while (pending_verdicts != 0);
         @(posedge clock);
         send_gaps = (phase == 0) || (phase == 2);
         rsp_holds = (phase == 0) || (phase == 3);
         phase_end = items_sent + PhaseItems;
         while (items_sent < phase_end) begin
            record_body.delete();
            kind = $urandom_range(0, 19);
            if (kind < 9) begin
               // Well-formed run of ticket messages.
               count = $urandom_range(1, 3);
               repeat (count) begin
                  length = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(7, 40))
                                                       : 24'($urandom_range(0, 6));
                  add_message(tcrc_pkg::HS_TICKET, length, int'(length));
               end
               send_record(tcrc_pkg::TYPE_HANDSHAKE, $urandom_range(0, 3) == 0);
            end else if (kind < 12) begin
               // Handshake record broken in one of several ways.
               length = 24'($urandom_range(0, 4));
               add_message(tcrc_pkg::HS_TICKET, length, int'(length));
               case ($urandom_range(0, 3))
                  0: record_body[0] = 8'($urandom_range(0, 255));
                  1: record_body = record_body[0:$urandom_range(0, record_body.size() - 2)];
                  2: begin
                     length = 24'($urandom_range(1, 24'hFFFFFF));
                     add_message(tcrc_pkg::HS_TICKET, length,
                                 (length > 2) ? int'($urandom_range(0, 2)) : 0);
                  end
                  default: repeat ($urandom_range(1, 3))
                     record_body.push_back(8'($urandom_range(0, 255)));
               endcase
               send_record(tcrc_pkg::TYPE_HANDSHAKE, $urandom_range(0, 3) == 0);
            end else if (kind < 15) begin
               // Alert, mostly two bytes, often a close notify.
               count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 2;
               repeat (count) record_body.push_back(8'($urandom_range(0, 255)));
               if (count > 1 && $urandom_range(0, 1) == 0) begin
                  record_body[1] = tcrc_pkg::ALERT_CLOSE_NOTIFY;
               end
               send_record(tcrc_pkg::TYPE_ALERT, $urandom_range(0, 3) == 0);
            end else if (kind < 17) begin
               repeat ($urandom_range(1, 4)) record_body.push_back(8'($urandom_range(0, 255)));
               send_record(tcrc_pkg::TYPE_CCS, $urandom_range(0, 3) == 0);
            end else if (kind < 19) begin
               // Any content type with random bytes.
               repeat ($urandom_range(1, 6)) record_body.push_back(8'($urandom_range(0, 255)));
               send_record(8'($urandom_range(0, 255)), $urandom_range(0, 1) == 0);
            end else begin
               send_record($urandom_range(0, 1) ? tcrc_pkg::TYPE_HANDSHAKE
                                                : 8'($urandom_range(0, 255)),
                           1'b0);
            end
         end
      end
      req_valid <= 1'b0;

      // Let the last verdicts come out, then give the block a few more cycles.
      do @(negedge clock); while (pending_verdicts != 0);
      repeat (6) @(posedge clock);

      $display("Sent %0d records in %0d items; %0d verdicts checked over four idling phases.",
               records_sent, items_sent, verdicts_checked);
      $display("Records covered every content type, clean and broken handshakes and alerts.");
      if (mismatch_count == 0 && pending_verdicts == 0) begin
         $display("[tls_control_record_classifier] OK");
      end else begin
         $display("[tls_control_record_classifier] ERROR");
      end
      $finish;
   end

endmodule
